>>> sv/traffic_light_mode_speed_fsm_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the traffic light controller
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_MODE_SPEED_FSM_ASSERT_SVH
`define TRAFFIC_LIGHT_MODE_SPEED_FSM_ASSERT_SVH

// Property that must hold at every clock edge.
`define TLMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property with a same-cycle antecedent.
`define TLMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/tlms_pkg.sv
// ----------------------------------------------------------------------------
// tlms_pkg
// Types, codes and helpers for the traffic light controller.
// ----------------------------------------------------------------------------
package tlms_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int TIME_W          = 14;
    localparam int SCALED_W        = TIME_W + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;

    localparam logic [TIME_W-1:0] GREEN_RESET  = 14'd3000;
    localparam logic [TIME_W-1:0] YELLOW_RESET = 14'd500;
    localparam logic [TIME_W-1:0] RED_RESET    = 14'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 2'd2;

    localparam logic [1:0] PH_CODE_RED    = 2'd0;
    localparam logic [1:0] PH_CODE_YELLOW = 2'd1;
    localparam logic [1:0] PH_CODE_GREEN  = 2'd2;
    localparam logic [1:0] PH_CODE_OFF    = 2'd3;

    localparam logic [1:0] MD_CODE_NORMAL       = 2'd0;
    localparam logic [1:0] MD_CODE_DISCONNECTED = 2'd1;
    localparam logic [1:0] MD_CODE_ALARM        = 2'd2;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_MODE  = 2'd1;
    localparam logic [1:0] BTN_SPEED = 2'd2;

    typedef enum logic [3:0] {
        PH_RED    = 4'b0001,
        PH_YELLOW = 4'b0010,
        PH_GREEN  = 4'b0100,
        PH_OFF    = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        MODE_NORMAL       = 3'b001,
        MODE_DISCONNECTED = 3'b010,
        MODE_ALARM        = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        SPEED_BASE   = 3'b001,
        SPEED_DOUBLE = 3'b010,
        SPEED_HALF   = 3'b100
    } speed_t;

    function automatic logic [SCALED_W-1:0] scale_time(
        input logic [TIME_W-1:0] base,
        input speed_t            sp
    );
        logic [SCALED_W-1:0] r;
        unique case (sp)
            SPEED_DOUBLE: r = {base, 1'b0};
            SPEED_HALF:   r = {2'b00, base[TIME_W-1:1]};
            default:      r = {1'b0, base};
        endcase
        return r;
    endfunction

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] c;
        unique case (ph)
            PH_RED:    c = PH_CODE_RED;
            PH_YELLOW: c = PH_CODE_YELLOW;
            PH_GREEN:  c = PH_CODE_GREEN;
            default:   c = PH_CODE_OFF;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] mode_code(input mode_t md);
        logic [1:0] c;
        unique case (md)
            MODE_DISCONNECTED: c = MD_CODE_DISCONNECTED;
            MODE_ALARM:        c = MD_CODE_ALARM;
            default:           c = MD_CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

>>> sv/traffic_light_mode_speed_fsm.sv
// ----------------------------------------------------------------------------
// traffic_light_mode_speed_fsm
// Traffic light controller with normal, disconnected and alarm modes and
// three timing speeds. Each input transaction carries a mode-button release,
// a speed-button release and a millisecond tick; each one produces exactly
// one output transaction with the lamp drive, the new phase, the mode and
// the last button seen. The block takes one transaction per clock: the
// whole update runs in one pass from the state registers to the output
// register, and a new transaction is taken whenever that output register is
// empty or being read in the same cycle, so with tready held high each
// result is out in the next cycle, at one transaction per clock. Timer
// registers are written on the cfg channel, which is always ready; index 3
// is ignored.
// ----------------------------------------------------------------------------
`include "traffic_light_mode_speed_fsm_assert.svh"

module traffic_light_mode_speed_fsm #(
    parameter int TIMER_WIDTH = tlms_pkg::TIMER_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side: [0] mode_press, [1] speed_press, [2] tick, [7:3] zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tlms_pkg::IN_TDATA_W-1:0]    s_tdata,
    // master side: [0] red_lamp, [1] yellow_lamp, [2] green_lamp,
    // [4:3] light_phase, [6:5] operating_mode, [8:7] last_button, [15:9] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tlms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlms_pkg::TIME_W-1:0]        cfg_data
);
    import tlms_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > SCALED_W) ? TIMER_WIDTH : SCALED_W;

    logic [TIME_W-1:0]      green_reg;
    logic [TIME_W-1:0]      yellow_reg;
    logic [TIME_W-1:0]      red_reg;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    mode_t                  mode_reg;
    mode_t                  mode_next;
    speed_t                 speed_reg;
    speed_t                 speed_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic [TIMER_WIDTH-1:0] elapsed_next;
    logic [1:0]             button_reg;
    logic [1:0]             button_next;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    logic                   mode_press;
    logic                   speed_press;
    logic                   tick;
    logic                   in_acc;
    phase_t                 phase_btn;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [SCALED_W-1:0]    green_s;
    logic [SCALED_W-1:0]    yellow_s;
    logic [SCALED_W-1:0]    red_s;
    logic [SCALED_W-1:0]    limit;
    phase_t                 phase_adv;
    logic                   timed;
    logic                   expired;

    assign mode_press  = s_tdata[0];
    assign speed_press = s_tdata[1];
    assign tick        = s_tdata[2];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // button handling: mode first, then speed
    always_comb
    begin
        mode_next   = mode_reg;
        phase_btn   = phase_reg;
        speed_next  = speed_reg;
        button_next = button_reg;
        if (mode_press)
        begin
            button_next = BTN_MODE;
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    mode_next = MODE_DISCONNECTED;
                    phase_btn = PH_OFF;
                end
                MODE_DISCONNECTED:
                begin
                    mode_next = MODE_ALARM;
                    phase_btn = PH_OFF;
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    phase_btn = PH_GREEN;
                end
            endcase
        end
        if (speed_press)
        begin
            button_next = BTN_SPEED;
            unique case (speed_reg)
                SPEED_BASE:   speed_next = SPEED_DOUBLE;
                SPEED_DOUBLE: speed_next = SPEED_HALF;
                default:      speed_next = SPEED_BASE;
            endcase
        end
    end

    assign elapsed_inc = (tick && (elapsed_reg != '1)) ? elapsed_reg + 1'b1 : elapsed_reg;

    assign green_s  = scale_time(green_reg, speed_next);
    assign yellow_s = scale_time(yellow_reg, speed_next);
    assign red_s    = scale_time(red_reg, speed_next);

    always_comb
    begin
        timed     = 1'b0;
        limit     = '0;
        phase_adv = phase_btn;
        unique case (mode_next)
            MODE_NORMAL:
            begin
                unique case (phase_btn)
                    PH_RED:
                    begin
                        timed = 1'b1; limit = red_s; phase_adv = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        timed = 1'b1; limit = green_s; phase_adv = PH_YELLOW;
                    end
                    PH_YELLOW:
                    begin
                        timed = 1'b1; limit = yellow_s; phase_adv = PH_RED;
                    end
                    default: ;
                endcase
            end
            MODE_DISCONNECTED:
            begin
                unique case (phase_btn)
                    PH_YELLOW:
                    begin
                        timed = 1'b1; limit = yellow_s; phase_adv = PH_OFF;
                    end
                    PH_OFF:
                    begin
                        timed = 1'b1; limit = yellow_s; phase_adv = PH_YELLOW;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                unique case (phase_btn)
                    PH_RED:
                    begin
                        timed = 1'b1; limit = red_s >> 1; phase_adv = PH_OFF;
                    end
                    PH_OFF:
                    begin
                        timed = 1'b1; limit = red_s >> 1; phase_adv = PH_RED;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign expired      = timed && (CMP_W'(elapsed_inc) >= CMP_W'(limit));
    assign phase_next   = expired ? phase_adv : phase_btn;
    assign elapsed_next = expired ? '0 : elapsed_inc;

    assign m_tdata_next = {7'd0, button_next, mode_code(mode_next), phase_code(phase_next),
                           phase_btn == PH_GREEN, phase_btn == PH_YELLOW,
                           phase_btn == PH_RED};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg  <= GREEN_RESET;
            yellow_reg <= YELLOW_RESET;
            red_reg    <= RED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GREEN:  green_reg  <= cfg_data;
                REG_YELLOW: yellow_reg <= cfg_data;
                REG_RED:    red_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_GREEN;
            mode_reg     <= MODE_NORMAL;
            speed_reg    <= SPEED_BASE;
            elapsed_reg  <= '0;
            button_reg   <= BTN_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg    <= phase_next;
                mode_reg     <= mode_next;
                speed_reg    <= speed_next;
                elapsed_reg  <= elapsed_next;
                button_reg   <= button_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    `TLMS_ASSERT_ALWAYS(a_phase_onehot, $onehot(phase_reg), "phase register not one-hot")
    `TLMS_ASSERT_IMPL(a_normal_phase, mode_reg == MODE_NORMAL, phase_reg != PH_OFF,
        "normal mode with light off")
    `TLMS_ASSERT_IMPL(a_disc_phase, mode_reg == MODE_DISCONNECTED,
        phase_reg == PH_YELLOW || phase_reg == PH_OFF, "disconnected mode phase illegal")
    `TLMS_ASSERT_IMPL(a_alarm_phase, mode_reg == MODE_ALARM,
        phase_reg == PH_RED || phase_reg == PH_OFF, "alarm mode phase illegal")
    `TLMS_ASSERT_IMPL(a_lamps, m_tvalid_reg, $onehot0(m_tdata_reg[2:0]),
        "more than one lamp driven")

endmodule

>>> tb/traffic_light_mode_speed_fsm_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_mode_speed_fsm_test
// Self-checking bench for the traffic light controller. A lamp state tracker
// in the bench mirrors mode, speed, phase and the elapsed-ms counter and
// predicts the output transaction for every accepted input transaction.
// Runs directed button/timer cases (reset timing, zero and full-scale
// durations), a back-pressure burst and 1850 random transactions with
// random timer settings and (bar one batch) random stalls on both streams.
// ----------------------------------------------------------------------------
module traffic_light_mode_speed_fsm_test;

    import tlms_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0] pad;
        logic [1:0] last_button;
        logic [1:0] mode;
        logic [1:0] phase;
        logic       green;
        logic       yellow;
        logic       red;
    } lamp_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TIME_W-1:0]      cfg_data = '0;

    // lamp state tracker
    logic [TIME_W-1:0]          timer_cfg [0:2];
    logic [1:0]                 signal_phase;
    logic [1:0]                 signal_mode;
    speed_t                     timing_speed;
    logic [TIMER_WIDTH_DEF-1:0] phase_elapsed_ms;
    logic [1:0]                 last_press;

    lamp_result_t pending_lamps [$];
    int           error_count = 0;
    int           hold_left = 0;
    bit           bursty = 1'b0;
    int           quiet_cycles = 0;

    traffic_light_mode_speed_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [15:0] speed_adjusted(input logic [TIME_W-1:0] base);
        logic [15:0] t;
        t = {2'b00, base};
        if (timing_speed == SPEED_DOUBLE)
            t = t << 1;
        else if (timing_speed == SPEED_HALF)
            t = t >> 1;
        return t;
    endfunction

    function automatic lamp_result_t next_lamp_state(input logic mode_press,
                                                     input logic speed_press,
                                                     input logic tick);
        lamp_result_t r;
        logic [1:0]   lamp;
        logic [15:0]  limit;
        logic [1:0]   next_phase;
        logic         timed;
        r = '0;
        limit = '0;
        next_phase = signal_phase;
        timed = 1'b0;
        if (mode_press)
        begin
            last_press = BTN_MODE;
            case (signal_mode)
                MD_CODE_NORMAL:
                begin
                    signal_mode = MD_CODE_DISCONNECTED;
                    signal_phase = PH_CODE_OFF;
                end
                MD_CODE_DISCONNECTED:
                begin
                    signal_mode = MD_CODE_ALARM;
                    signal_phase = PH_CODE_OFF;
                end
                default:
                begin
                    signal_mode = MD_CODE_NORMAL;
                    signal_phase = PH_CODE_GREEN;
                end
            endcase
        end
        if (speed_press)
        begin
            last_press = BTN_SPEED;
            case (timing_speed)
                SPEED_BASE:   timing_speed = SPEED_DOUBLE;
                SPEED_DOUBLE: timing_speed = SPEED_HALF;
                default:      timing_speed = SPEED_BASE;
            endcase
        end
        lamp = signal_phase;
        if (tick && phase_elapsed_ms != '1)
            phase_elapsed_ms = phase_elapsed_ms + 1'b1;
        case (signal_mode)
            MD_CODE_NORMAL:
            begin
                timed = 1'b1;
                case (signal_phase)
                    PH_CODE_RED:
                    begin
                        limit = speed_adjusted(timer_cfg[REG_RED]);
                        next_phase = PH_CODE_GREEN;
                    end
                    PH_CODE_GREEN:
                    begin
                        limit = speed_adjusted(timer_cfg[REG_GREEN]);
                        next_phase = PH_CODE_YELLOW;
                    end
                    PH_CODE_YELLOW:
                    begin
                        limit = speed_adjusted(timer_cfg[REG_YELLOW]);
                        next_phase = PH_CODE_RED;
                    end
                    default: timed = 1'b0;
                endcase
            end
            MD_CODE_DISCONNECTED:
            begin
                limit = speed_adjusted(timer_cfg[REG_YELLOW]);
                timed = 1'b1;
                if (signal_phase == PH_CODE_YELLOW)
                    next_phase = PH_CODE_OFF;
                else if (signal_phase == PH_CODE_OFF)
                    next_phase = PH_CODE_YELLOW;
                else
                    timed = 1'b0;
            end
            MD_CODE_ALARM:
            begin
                limit = speed_adjusted(timer_cfg[REG_RED]) >> 1;
                timed = 1'b1;
                if (signal_phase == PH_CODE_RED)
                    next_phase = PH_CODE_OFF;
                else if (signal_phase == PH_CODE_OFF)
                    next_phase = PH_CODE_RED;
                else
                    timed = 1'b0;
            end
            default: timed = 1'b0;
        endcase
        if (timed && phase_elapsed_ms >= limit)
        begin
            signal_phase = next_phase;
            phase_elapsed_ms = '0;
        end
        r.red = (lamp == PH_CODE_RED);
        r.yellow = (lamp == PH_CODE_YELLOW);
        r.green = (lamp == PH_CODE_GREEN);
        r.phase = signal_phase;
        r.mode = signal_mode;
        r.last_button = last_press;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("%t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_lamp_result(input lamp_result_t got);
        lamp_result_t want;
        if (pending_lamps.size() == 0)
        begin
            report_mismatch($sformatf("result 0x%04h with none pending", got));
            return;
        end
        want = pending_lamps.pop_front();
        compare_field("red_lamp", got.red, want.red);
        compare_field("yellow_lamp", got.yellow, want.yellow);
        compare_field("green_lamp", got.green, want.green);
        compare_field("light_phase", got.phase, want.phase);
        compare_field("operating_mode", got.mode, want.mode);
        compare_field("last_button", got.last_button, want.last_button);
        compare_field("tdata padding", got.pad, want.pad);
    endtask

    // receiver: checks results, drives tready, honors hold-off requests
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_lamp_result(m_tdata);
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (bursty)
            m_tready <= ($urandom_range(99) >= 36);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= QUIET_LIMIT)
        begin
            $display("traffic_light_mode_speed_fsm_test: done, errors");
            $finish;
        end
    end

    // tvalid is left high after acceptance; release_bus lowers it
    task automatic send_item(input logic mode_press, input logic speed_press,
                             input logic tick);
        while (bursty && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, tick, speed_press, mode_press};
        do
            @(posedge clk);
        while (!s_tready);
        pending_lamps.push_back(next_lamp_state(mode_press, speed_press, tick));
    endtask

    task automatic release_bus();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_lamps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timer(input logic [CFG_IDX_W-1:0] idx,
                               input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_RED)
            timer_cfg[idx] = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_timers(input logic [TIME_W-1:0] green,
                               input logic [TIME_W-1:0] yellow,
                               input logic [TIME_W-1:0] red);
        release_bus();
        wait_drained();
        write_timer(REG_GREEN, green);
        write_timer(REG_YELLOW, yellow);
        write_timer(REG_RED, red);
    endtask

    function automatic logic [TIME_W-1:0] pick_duration();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 80)
            return TIME_W'($urandom_range(10, 1));
        if (r < 95)
            return TIME_W'($urandom_range(60, 11));
        return TIME_W'($urandom_range(400, 61));
    endfunction

    task automatic test_buttons_at_reset();
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b0, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b1, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_zero_durations();
        load_timers('0, '0, '0);
        write_timer(REG_UNUSED, '1);
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b0, 1'b1);
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b0, 1'b1);
        send_item(1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_max_durations();
        load_timers('1, '1, '1);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b0, 1'b1);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b0, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_backpressure();
        load_timers(TIME_W'(3), TIME_W'(2), TIME_W'(4));
        bursty = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (40)
            send_item(1'b0, $urandom_range(99) < 5, $urandom_range(99) < 80);
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 10; ph++)
        begin
            load_timers(pick_duration(), pick_duration(), pick_duration());
            bursty = (ph != 3);
            repeat (185)
                send_item($urandom_range(99) < 4, $urandom_range(99) < 5,
                          $urandom_range(99) < 80);
        end
    endtask

    initial
    begin
        timer_cfg[REG_GREEN] = GREEN_RESET;
        timer_cfg[REG_YELLOW] = YELLOW_RESET;
        timer_cfg[REG_RED] = RED_RESET;
        signal_phase = PH_CODE_GREEN;
        signal_mode = MD_CODE_NORMAL;
        timing_speed = SPEED_BASE;
        phase_elapsed_ms = '0;
        last_press = BTN_NONE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buttons_at_reset();
        test_zero_durations();
        test_max_durations();
        test_backpressure();
        test_random_traffic();

        release_bus();
        bursty = 1'b0;
        while (pending_lamps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("traffic_light_mode_speed_fsm_test: done, clean");
        else
            $display("traffic_light_mode_speed_fsm_test: done, errors");
        $finish;
    end

endmodule
